// ===== src/gds_pkg.sv =====
// Package for the damping stress core: widths, datapath opcode and command types.
// Used by gds_ctrl, gds_datapath and green_damping_stress_core.
package gds_pkg;
    localparam int ElemW  = 32;
    localparam int IdxW   = 4;
    localparam int OutW   = 48;
    localparam int EnW    = 47;
    localparam int AccW   = 100;
    localparam int NumEl  = 9;
    localparam int PartW  = 25;
    localparam int PartSh = 24;
    localparam logic [IdxW-1:0] LastIdx = 4'd8;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_S_MAC,
        OP_S_END,
        OP_N_MAC,
        OP_T_MAC,
        OP_T_END,
        OP_MU,
        OP_MU_END
    } op_t;

    typedef struct packed {
        op_t            op;
        logic [1:0]     k;
        logic [1:0]     h;
        logic [IdxW-1:0] i;
        logic [IdxW-1:0] j;
        logic           sel_en;
    } cmd_t;
endpackage

// ===== src/gds_datapath.sv =====
// Datapath: operand stores, two 25x25 partial-product multipliers, accumulator, saturation.
// Depends on gds_pkg; driven by gds_ctrl through cmd_t.
module gds_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ld_en,
    input  logic [gds_pkg::IdxW-1:0]      ld_idx,
    input  logic signed [gds_pkg::ElemW-1:0] ld_grad,
    input  logic signed [gds_pkg::ElemW-1:0] ld_rate,
    input  logic [gds_pkg::ElemW-1:0]     mu,
    input  gds_pkg::cmd_t                 cmd,
    output logic signed [gds_pkg::OutW-1:0] stress,
    output logic [gds_pkg::EnW-1:0]       energy
);
    import gds_pkg::*;

    logic signed [ElemW-1:0] grad_reg [NumEl];
    logic signed [ElemW-1:0] rate_reg [NumEl];
    logic signed [OutW-1:0]  s_reg [NumEl];
    logic signed [AccW-1:0]  acc_reg;
    logic signed [OutW-1:0]  t_reg;
    logic [EnW-1:0]          n_reg;
    logic signed [OutW-1:0]  stress_reg;
    logic [EnW-1:0]          energy_reg;
    logic signed [OutW:0]    ma, mb, mc, md;
    logic signed [PartW-1:0] pa, pb, pc, pd;
    logic signed [2*PartW-1:0] pp_ab, pp_cd;
    logic [5:0]              part_sh;
    logic [IdxW-1:0]         ik_idx, jk_idx, ki_idx, ji_idx;
    logic signed [AccW-1:0]  prod_reg, prod2_reg;
    op_t                     op_d;

    function automatic logic signed [OutW-1:0] sat48(input logic signed [AccW-1:0] v);
        logic signed [AccW-1:0] sh;
        sh = v >>> FRAC_BITS;
        if (sh > $signed({{(AccW-OutW){1'b0}}, 1'b0, {(OutW-1){1'b1}}}))
            return {1'b0, {(OutW-1){1'b1}}};
        else if (sh < -$signed({{(AccW-OutW){1'b0}}, 1'b1, {(OutW-1){1'b0}}}))
            return {1'b1, {(OutW-1){1'b0}}};
        else
            return sh[OutW-1:0];
    endfunction

    function automatic logic [EnW-1:0] satu(input logic signed [AccW-1:0] v, input int s);
        logic signed [AccW-1:0] sh;
        sh = v >>> s;
        if (sh > $signed({{(AccW-EnW){1'b0}}, {EnW{1'b1}}}))
            return {EnW{1'b1}};
        else
            return sh[EnW-1:0];
    endfunction

    assign ik_idx = IdxW'(cmd.i * 3 + cmd.k);
    assign jk_idx = IdxW'(cmd.j * 3 + cmd.k);
    assign ki_idx = IdxW'(cmd.k * 3 + cmd.i);
    assign ji_idx = IdxW'(cmd.j * 3 + cmd.i);

    // operand select
    always_comb begin
        ma = '0; mb = '0; mc = '0; md = '0;
        case (cmd.op)
            OP_S_MAC: begin
                ma = (OutW+1)'(grad_reg[ik_idx]);
                mb = (OutW+1)'(rate_reg[jk_idx]);
                mc = (OutW+1)'(rate_reg[ik_idx]);
                md = (OutW+1)'(grad_reg[jk_idx]);
            end
            OP_N_MAC: begin
                ma = (OutW+1)'(s_reg[cmd.i]);
                mb = (OutW+1)'(s_reg[cmd.i]);
            end
            OP_T_MAC: begin
                ma = (OutW+1)'(grad_reg[ki_idx]);
                mb = (OutW+1)'(s_reg[jk_idx]);
            end
            OP_MU: begin
                ma = {{(OutW+1-ElemW){1'b0}}, mu};
                mb = cmd.sel_en ? $signed({2'b00, n_reg}) : (OutW+1)'(t_reg);
            end
            default: ;
        endcase
    end

    // split each operand into a signed high part and an unsigned low part;
    // cmd.h picks one of the four part pairs per pass
    always_comb begin
        pa = cmd.h[0] ? ma[OutW:PartSh] : {1'b0, ma[PartSh-1:0]};
        pb = cmd.h[1] ? mb[OutW:PartSh] : {1'b0, mb[PartSh-1:0]};
        pc = cmd.h[0] ? mc[OutW:PartSh] : {1'b0, mc[PartSh-1:0]};
        pd = cmd.h[1] ? md[OutW:PartSh] : {1'b0, md[PartSh-1:0]};
        pp_ab = pa * pb;
        pp_cd = pc * pd;
        part_sh = (cmd.h[0] ? 6'(PartSh) : 6'd0) + (cmd.h[1] ? 6'(PartSh) : 6'd0);
    end

    always_ff @(posedge aclk) begin
        if (ld_en) begin
            grad_reg[ld_idx] <= ld_grad;
            rate_reg[ld_idx] <= ld_rate;
        end
        prod_reg  <= AccW'(pp_ab) <<< part_sh;
        prod2_reg <= AccW'(pp_cd) <<< part_sh;
        case (op_d)
            OP_S_MAC, OP_N_MAC, OP_T_MAC, OP_MU: acc_reg <= acc_reg + prod_reg + prod2_reg;
            default: ;
        endcase
        case (cmd.op)
            OP_CLR: acc_reg <= '0;
            OP_S_END: begin
                s_reg[ji_idx] <= sat48(acc_reg);
                acc_reg <= '0;
            end
            OP_T_END: begin
                if (cmd.sel_en) n_reg <= satu(acc_reg, FRAC_BITS + 2);
                else t_reg <= sat48(acc_reg);
                acc_reg <= '0;
            end
            OP_MU_END: begin
                if (cmd.sel_en) energy_reg <= satu(acc_reg, FRAC_BITS);
                else stress_reg <= sat48(acc_reg);
                acc_reg <= '0;
            end
            default: ;
        endcase
        if (!aresetn) begin
            for (int e = 0; e < NumEl; e++) begin
                grad_reg[e] <= '0;
                rate_reg[e] <= '0;
            end
            acc_reg <= '0;
            op_d <= OP_NONE;
        end else begin
            op_d <= cmd.op;
        end
    end

    assign stress = stress_reg;
    assign energy = energy_reg;
endmodule

// ===== src/gds_ctrl.sv =====
// Controller: sequences S, energy and stress work per output; owns the result handshake.
// Depends on gds_pkg; commands gds_datapath.
module gds_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic                     m_ready,
    output logic                     busy,
    output gds_pkg::cmd_t            cmd,
    output logic                     m_valid,
    output logic [gds_pkg::IdxW-1:0] m_idx
);
    import gds_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_S, ST_S_WAIT, ST_S_END, ST_N, ST_N_WAIT, ST_N_END, ST_N_MU,
        ST_E_WAIT, ST_E_END, ST_T, ST_T_WAIT, ST_T_END, ST_T_MU, ST_MU_WAIT,
        ST_MU_END, ST_OUT
    } state_t;

    state_t          state_reg;
    logic [1:0]      k_reg;
    logic [1:0]      h_reg;
    logic [IdxW-1:0] i_reg, j_reg, n_reg;
    logic [1:0]      wait_reg;
    logic            valid_reg;

    always_comb begin
        cmd = '{op: OP_NONE, k: k_reg, h: h_reg, i: i_reg, j: j_reg, sel_en: 1'b0};
        case (state_reg)
            ST_S: cmd.op = OP_S_MAC;
            ST_S_END: cmd.op = OP_S_END;
            ST_N: begin cmd.op = OP_N_MAC; cmd.i = n_reg; end
            ST_N_END: begin cmd.op = OP_T_END; cmd.sel_en = 1'b1; end
            ST_N_MU: begin cmd.op = OP_MU; cmd.sel_en = 1'b1; end
            ST_E_END: begin cmd.op = OP_MU_END; cmd.sel_en = 1'b1; end
            ST_T: cmd.op = OP_T_MAC;
            ST_T_END: cmd.op = OP_T_END;
            ST_T_MU: cmd.op = OP_MU;
            ST_MU_END: cmd.op = OP_MU_END;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            k_reg <= '0; h_reg <= '0; i_reg <= '0; j_reg <= '0; n_reg <= '0;
            wait_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: if (start) begin
                    state_reg <= ST_S;
                    k_reg <= '0; h_reg <= '0; i_reg <= '0; j_reg <= '0;
                end
                ST_S: begin
                    h_reg <= h_reg + 2'd1;
                    if (h_reg == 2'd3) begin
                        k_reg <= k_reg + 2'd1;
                        if (k_reg == 2'd2) begin
                            k_reg <= '0;
                            state_reg <= ST_S_WAIT;
                            wait_reg <= '0;
                        end
                    end
                end
                ST_S_WAIT: begin
                    wait_reg <= wait_reg + 2'd1;
                    if (wait_reg == 2'd1) state_reg <= ST_S_END;
                end
                ST_S_END: begin
                    state_reg <= ST_S;
                    if (i_reg == 4'd2) begin
                        i_reg <= '0;
                        if (j_reg == 4'd2) begin
                            j_reg <= '0;
                            n_reg <= '0;
                            state_reg <= ST_N;
                        end else j_reg <= j_reg + 4'd1;
                    end else i_reg <= i_reg + 4'd1;
                end
                ST_N: begin
                    h_reg <= h_reg + 2'd1;
                    if (h_reg == 2'd3) begin
                        n_reg <= n_reg + 4'd1;
                        if (n_reg == LastIdx) begin
                            state_reg <= ST_N_WAIT;
                            wait_reg <= '0;
                        end
                    end
                end
                ST_N_WAIT: begin
                    wait_reg <= wait_reg + 2'd1;
                    if (wait_reg == 2'd1) state_reg <= ST_N_END;
                end
                ST_N_END: state_reg <= ST_N_MU;
                ST_N_MU: begin
                    h_reg <= h_reg + 2'd1;
                    if (h_reg == 2'd3) begin
                        state_reg <= ST_E_WAIT;
                        wait_reg <= '0;
                    end
                end
                ST_E_WAIT: begin
                    wait_reg <= wait_reg + 2'd1;
                    if (wait_reg == 2'd1) state_reg <= ST_E_END;
                end
                ST_E_END: begin
                    state_reg <= ST_T;
                    n_reg <= '0;
                end
                ST_T: begin
                    h_reg <= h_reg + 2'd1;
                    if (h_reg == 2'd3) begin
                        k_reg <= k_reg + 2'd1;
                        if (k_reg == 2'd2) begin
                            k_reg <= '0;
                            state_reg <= ST_T_WAIT;
                            wait_reg <= '0;
                        end
                    end
                end
                ST_T_WAIT: begin
                    wait_reg <= wait_reg + 2'd1;
                    if (wait_reg == 2'd1) state_reg <= ST_T_END;
                end
                ST_T_END: state_reg <= ST_T_MU;
                ST_T_MU: begin
                    h_reg <= h_reg + 2'd1;
                    if (h_reg == 2'd3) begin
                        state_reg <= ST_MU_WAIT;
                        wait_reg <= '0;
                    end
                end
                ST_MU_WAIT: begin
                    wait_reg <= wait_reg + 2'd1;
                    if (wait_reg == 2'd1) state_reg <= ST_MU_END;
                end
                ST_MU_END: begin
                    state_reg <= ST_OUT;
                    valid_reg <= 1'b1;
                end
                ST_OUT: if (m_ready) begin
                    valid_reg <= 1'b0;
                    if (n_reg == LastIdx) state_reg <= ST_IDLE;
                    else begin
                        n_reg <= n_reg + 4'd1;
                        state_reg <= ST_T;
                        if (i_reg == 4'd2) begin
                            i_reg <= '0;
                            j_reg <= j_reg + 4'd1;
                        end else i_reg <= i_reg + 4'd1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy    = (state_reg != ST_IDLE);
    assign m_valid = valid_reg;
    assign m_idx   = n_reg;
endmodule

// ===== src/green_damping_stress_core.sv =====
// Top level of the Green strain-rate damping stress core.
// Instantiates gds_ctrl and gds_datapath; uses gds_pkg.
//
//  channel | ports                                             | direction
//  --------+---------------------------------------------------+----------
//  input   | s_valid s_ready s_elem_index s_grad_value s_rate_value | in
//  result  | m_valid m_ready m_out_index m_stress_value m_energy_value m_last | out
//  config  | cfg_we cfg_wdata (damping_coeff)                  | in
//
// A load of elements 0..7 only writes the stores. Element 8 starts an evaluation
// that holds s_ready low: 9 S entries, then the energy, then 9 stress
// entries, each followed by its output and the m_ready wait. Every product
// takes four passes through the shared 25x25 partial-product multipliers.
// Reset clears the stores and sets mu to 1.0. A stalled result holds.
module green_damping_stress_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [31:0]                     cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gds_pkg::IdxW-1:0]        s_elem_index,
    input  logic signed [gds_pkg::ElemW-1:0] s_grad_value,
    input  logic signed [gds_pkg::ElemW-1:0] s_rate_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gds_pkg::IdxW-1:0]        m_out_index,
    output logic signed [gds_pkg::OutW-1:0] m_stress_value,
    output logic [gds_pkg::EnW-1:0]         m_energy_value,
    output logic                            m_last
);
    import gds_pkg::*;

    logic [ElemW-1:0] mu_reg;
    logic             busy, s_xfer, ld_ok;
    cmd_t             cmd;

    // hold mu until written
    always_ff @(posedge aclk) begin
        if (!aresetn) mu_reg <= ElemW'(1 << FRAC_BITS);
        else if (cfg_we) mu_reg <= cfg_wdata;
    end

    assign s_ready = !busy;
    assign s_xfer  = s_valid && s_ready;
    // drop out-of-range indexes
    assign ld_ok   = s_xfer && (s_elem_index <= LastIdx);

    gds_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .start(s_xfer && (s_elem_index == LastIdx)),
        .m_ready(m_ready), .busy(busy), .cmd(cmd),
        .m_valid(m_valid), .m_idx(m_out_index)
    );

    gds_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .ld_en(ld_ok), .ld_idx(s_elem_index),
        .ld_grad(s_grad_value), .ld_rate(s_rate_value),
        .mu(mu_reg), .cmd(cmd),
        .stress(m_stress_value), .energy(m_energy_value)
    );

    assign m_last = (m_out_index == LastIdx);
endmodule
